### design/sa_pkg.sv
// ----------------------------------------------------------------------------
// sa_pkg
// shared widths, constants and codes of the stack allocator
// ----------------------------------------------------------------------------
package sa_pkg;

    localparam int ADDR_W              = 48;
    localparam int OFF_W               = 32;
    localparam int CFG_IDX_W           = 2;
    localparam int CFG_DATA_W          = 48;
    // align must be a power of two
    localparam int HEADER_BYTES        = 8;
    localparam int ALIGN_BYTES         = 8;
    localparam int MAX_LIVE_BLOCKS_DEF = 256;
    localparam int CAPACITY_RESET      = 65536;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_OOM     = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_NOT_TOP = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 2'd0,
        CFG_BASE     = 2'd1
    } t_cfg_reg;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

endpackage

### design/sa_ram.sv
// ----------------------------------------------------------------------------
// sa_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module sa_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/stack_allocator.sv
// ----------------------------------------------------------------------------
// stack_allocator
// lifo bump allocator with a header offset stack held in a ram
// ----------------------------------------------------------------------------
// the result strobe is registered and rises in the cycle after the item is taken
// allocate and failing requests: one item per cycle while busy is low
// free that uncovers an older block: busy for the ram read of
//   the next header offset
// synchronous active-low reset clears offsets, counts, peak and base, sets
//   capacity to its default; ram is not cleared, the receiver cannot stall
module stack_allocator #(
    parameter int MAX_LIVE_BLOCKS = sa_pkg::MAX_LIVE_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic [sa_pkg::OFF_W-1:0]      i_request_bytes,
    input  logic [sa_pkg::ADDR_W-1:0]     i_free_address,
    output logic                          o_result_valid,
    output logic [sa_pkg::ADDR_W-1:0]     o_block_address,
    output logic [2:0]                    o_status,
    output logic [sa_pkg::OFF_W-1:0]      o_used_bytes,
    output logic [sa_pkg::OFF_W-1:0]      o_peak_bytes,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sa_pkg::*;

    localparam int LCW   = $clog2(MAX_LIVE_BLOCKS + 1);
    localparam int RAM_AW = (MAX_LIVE_BLOCKS > 1) ? $clog2(MAX_LIVE_BLOCKS) : 1;

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    t_state              r_state, n_state;
    logic                r_valid, n_valid;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    t_status             r_status, n_status;
    logic [OFF_W-1:0]    r_cur, n_cur;
    logic [OFF_W-1:0]    r_top, n_top;
    logic [LCW-1:0]      r_live, n_live;
    logic [OFF_W-1:0]    r_peak, n_peak;
    logic [OFF_W-1:0]    r_cap, n_cap;
    logic [ADDR_W-1:0]   r_base, n_base;

    logic                accept;
    logic [OFF_W:0]      hdr_ext;
    logic [OFF_W+1:0]    end_ext;
    logic                fits;
    logic [ADDR_W-1:0]   alloc_addr;
    logic [ADDR_W-1:0]   top_addr;
    logic [RAM_AW-1:0]   wr_idx;
    logic [RAM_AW-1:0]   rd_idx;
    logic                wr_en;
    logic                rd_en;
    logic [OFF_W-1:0]    rd_data;

    assign accept = start && !busy;

    assign hdr_ext = ({1'b0, r_cur} + (OFF_W+1)'(ALIGN_BYTES - 1))
                   & ~(OFF_W+1)'(ALIGN_BYTES - 1);
    assign end_ext = {1'b0, hdr_ext} + (OFF_W+2)'(HEADER_BYTES)
                   + {2'b00, i_request_bytes};
    assign fits    = end_ext <= {2'b00, r_cap};

    assign alloc_addr = r_base + ADDR_W'(hdr_ext[OFF_W-1:0]) + ADDR_W'(HEADER_BYTES);
    assign top_addr   = r_base + ADDR_W'(r_top) + ADDR_W'(HEADER_BYTES);

    assign wr_idx = RAM_AW'(r_live - LCW'(1));
    assign rd_idx = RAM_AW'(r_live - LCW'(2));

    sa_ram #(
        .WIDTH (OFF_W),
        .DEPTH (MAX_LIVE_BLOCKS)
    ) u_hdr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_idx),
        .i_wr_data (r_top),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_idx),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state  = r_state;
        n_valid  = accept;
        n_addr   = '0;
        n_status = ST_OK;
        n_cur    = r_cur;
        n_top    = r_top;
        n_live   = r_live;
        n_peak   = r_peak;
        n_cap    = r_cap;
        n_base   = r_base;
        wr_en    = 1'b0;
        rd_en    = 1'b0;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CAPACITY: n_cap  = i_cfg_data[OFF_W-1:0];
                CFG_BASE:     n_base = i_cfg_data[ADDR_W-1:0];
                default:      ;
            endcase
        end

        if (r_state == S_POP) begin
            n_top   = rd_data;
            n_state = S_IDLE;
        end else if (accept) begin
            if (i_action == ACT_ALLOC) begin
                if (!fits) begin
                    n_status = ST_OOM;
                end else if (r_live == LCW'(MAX_LIVE_BLOCKS)) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en  = (r_live != '0);
                    n_top  = hdr_ext[OFF_W-1:0];
                    n_live = r_live + LCW'(1);
                    n_cur  = end_ext[OFF_W-1:0];
                    n_addr = alloc_addr;
                    if (end_ext[OFF_W-1:0] > r_peak) begin
                        n_peak = end_ext[OFF_W-1:0];
                    end
                end
            end else begin
                if (r_live == '0) begin
                    n_status = ST_EMPTY;
                end else if (i_free_address != top_addr) begin
                    n_status = ST_NOT_TOP;
                end else begin
                    n_cur  = r_top;
                    n_live = r_live - LCW'(1);
                    if (r_live > LCW'(1)) begin
                        rd_en   = 1'b1;
                        n_state = S_POP;
                    end else begin
                        n_top = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_cur   <= '0;
            r_top   <= '0;
            r_live  <= '0;
            r_peak  <= '0;
            r_cap   <= OFF_W'(CAPACITY_RESET);
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_cur   <= n_cur;
            r_top   <= n_top;
            r_live  <= n_live;
            r_peak  <= n_peak;
            r_cap   <= n_cap;
            r_base  <= n_base;
        end
        r_addr   <= n_addr;
        r_status <= n_status;
    end

    assign busy            = (r_state == S_POP);
    assign o_result_valid  = r_valid;
    assign o_block_address = r_addr;
    assign o_status        = r_status;
    assign o_used_bytes    = r_cur;
    assign o_peak_bytes    = r_peak;
    assign o_cfg_ready     = 1'b1;

    a_pop_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("header pop stalled more than one cycle");

    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_result_valid)
        else $error("accepted item gave no result");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= LCW'(MAX_LIVE_BLOCKS))
        else $error("live block count above limit");

    a_used_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_peak)
        else $error("current offset above peak");

    a_empty_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live == '0 |-> r_top == '0)
        else $error("top header offset nonzero with empty stack");

endmodule
